// ===== rtl/fice_pkg.sv =====
// shared types and constants for the frame idle cache evictor
package fice_pkg;

	localparam int unsigned ID_W    = 32;
	localparam int unsigned FRAME_W = 32;
	localparam int unsigned COUNT_W = 7;

	localparam logic [COUNT_W-1:0] COUNT_MAX      = 7'd127;
	localparam logic [FRAME_W-1:0] FRAME_ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [FRAME_W-1:0] FRAME_RESTART  = 32'd1;
	localparam logic [FRAME_W-1:0] MAX_IDLE_RESET = 32'd60;

	// apb register map
	localparam int unsigned  PADDR_W          = 2;
	localparam logic [1:0]   REG_MAX_IDLE_ADDR = 2'd0;

	typedef enum logic [1:0] {
		OP_BEGIN  = 2'd0,
		OP_TOUCH  = 2'd1,
		OP_EVICT  = 2'd2,
		OP_INSERT = 2'd3
	} op_t;

	// one queued operation
	typedef struct packed {
		op_t             op;
		logic [ID_W-1:0] obj_id;
	} item_t;

	// tag ram word
	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] asset;
	} tag_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRAP,
		ST_HOLD
	} back_state_t;

endpackage

// ===== rtl/fice_if.sv =====
// request and response channel interfaces

interface fice_req_if import fice_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [1:0]      opcode;
	logic [ID_W-1:0] obj_id;

	modport source (output valid, output opcode, output obj_id, input ready);
	modport sink   (input valid, input opcode, input obj_id, output ready);
endinterface

interface fice_rsp_if import fice_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               found;
	logic               table_full;
	logic [COUNT_W-1:0] evicted_count;
	logic [FRAME_W-1:0] current_frame;

	modport source (output valid, output found, output table_full, output evicted_count,
		output current_frame, input ready);
	modport sink   (input valid, input found, input table_full, input evicted_count,
		input current_frame, output ready);
endinterface

// ===== rtl/fice_ram.sv =====
// generic simple dual-port ram with registered read
module fice_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/fice_front.sv =====
// front end: accepts request beats, decodes the opcode and queues them
module fice_front import fice_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	fice_req_if.sink        req,
	output logic            q_valid,
	output item_t           q_item,
	input  logic            q_pop
);

	localparam int unsigned DEPTH = 2;

	item_t      slot_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      item_in;

	// classify the incoming beat
	always_comb begin
		item_in.obj_id = req.obj_id;
		unique case (req.opcode)
			OP_BEGIN: item_in.op = OP_BEGIN;
			OP_TOUCH: item_in.op = OP_TOUCH;
			OP_EVICT: item_in.op = OP_EVICT;
			default:  item_in.op = OP_INSERT;
		endcase
	end

	assign req.ready = (cnt_q != 2'(DEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/fice_back.sv =====
// back end: frame counter, entry table scans and response register
module fice_back import fice_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	input  logic [FRAME_W-1:0] max_idle,
	fice_rsp_if.source         rsp
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	back_state_t        state_q, state_d;
	op_t                op_q;
	logic [ID_W-1:0]    id_q;
	logic [FRAME_W-1:0] frame_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic               rv_s1;
	logic [IDX_W-1:0]   ridx_s1;
	logic               free_hit_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               res_found_q;
	logic               res_full_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               out_valid_q;
	logic               out_found_q;
	logic               out_full_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [FRAME_W-1:0] out_frame_q;

	// ram ports
	logic               tag_we, stamp_we, rd_issue;
	logic [IDX_W-1:0]   tag_waddr, stamp_waddr, rd_addr;
	tag_t               tag_wdata, tag_rd;
	logic [FRAME_W-1:0] stamp_wdata, stamp_rd;

	// scan decode
	logic               hit, idle, last, is_free, free_avail, scan_done, evict_now;
	logic               out_free, load_out;
	logic [IDX_W-1:0]   free_sel;
	logic [FRAME_W-1:0] age;

	fice_ram #(.WIDTH($bits(tag_t)), .DEPTH(ENTRIES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.re    (rd_issue),
		.raddr (rd_addr),
		.rdata (tag_rd)
	);

	fice_ram #(.WIDTH(FRAME_W), .DEPTH(ENTRIES)) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (stamp_waddr),
		.wdata (stamp_wdata),
		.re    (rd_issue),
		.raddr (rd_addr),
		.rdata (stamp_rd)
	);

	// per-entry decode of the word returned by the rams
	always_comb begin
		age        = frame_q - stamp_rd;
		hit        = tag_rd.valid && (tag_rd.asset == id_q);
		idle       = (frame_q > stamp_rd) && (age > max_idle);
		last       = (ridx_s1 == IDX_LAST);
		is_free    = !tag_rd.valid;
		free_avail = free_hit_q || is_free;
		free_sel   = free_hit_q ? free_idx_q : ridx_s1;
		evict_now  = rv_s1 && (op_q == OP_EVICT) && tag_rd.valid && idle;
		scan_done  = rv_s1 && (((op_q != OP_EVICT) && hit) || last);
		out_free   = !out_valid_q || rsp.ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (rd_cnt_q == CNT_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.op == OP_BEGIN) begin
						state_d = (frame_q == FRAME_ALL_ONES) ? ST_WRAP : ST_HOLD;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_HOLD;
			end
			ST_WRAP: begin
				if (rd_cnt_q == CNT_LAST) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ram control and handshakes
	always_comb begin
		q_pop       = 1'b0;
		rd_issue    = 1'b0;
		rd_addr     = rd_cnt_q[IDX_W-1:0];
		tag_we      = 1'b0;
		tag_waddr   = ridx_s1;
		tag_wdata   = '0;
		stamp_we    = 1'b0;
		stamp_waddr = ridx_s1;
		stamp_wdata = frame_q;
		load_out    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				tag_we    = 1'b1;
				tag_waddr = rd_cnt_q[IDX_W-1:0];
			end
			ST_IDLE: begin
				q_pop = q_valid;
			end
			ST_SCAN: begin
				rd_issue = (rd_cnt_q < CNT_END);
				if (rv_s1) begin
					case (op_q)
						OP_TOUCH: begin
							stamp_we = hit;
						end
						OP_INSERT: begin
							if (hit) begin
								stamp_we = 1'b1;
							end else if (last && free_avail) begin
								tag_we      = 1'b1;
								tag_waddr   = free_sel;
								tag_wdata   = '{valid: 1'b1, asset: id_q};
								stamp_we    = 1'b1;
								stamp_waddr = free_sel;
							end
						end
						OP_EVICT: begin
							if (evict_now) begin
								tag_we    = 1'b1;
								tag_wdata = '{valid: 1'b0, asset: tag_rd.asset};
							end
						end
						default: ;
					endcase
				end
			end
			ST_WRAP: begin
				stamp_we    = 1'b1;
				stamp_waddr = rd_cnt_q[IDX_W-1:0];
				stamp_wdata = FRAME_RESTART;
			end
			ST_HOLD: begin
				load_out = out_free;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			frame_q     <= '0;
			rd_cnt_q    <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= rd_issue;
			if (state_q == ST_CLEAR || state_q == ST_WRAP || rd_issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end else if (q_pop) begin
				rd_cnt_q <= '0;
			end
			if (q_pop && q_item.op == OP_BEGIN) begin
				frame_q <= (frame_q == FRAME_ALL_ONES) ? FRAME_RESTART : frame_q + 32'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		ridx_s1 <= rd_addr;
		if (q_pop) begin
			op_q        <= q_item.op;
			id_q        <= q_item.obj_id;
			free_hit_q  <= 1'b0;
			res_found_q <= 1'b0;
			res_full_q  <= 1'b0;
			res_count_q <= '0;
		end else if (state_q == ST_SCAN && rv_s1) begin
			if (op_q == OP_INSERT && !hit && is_free && !free_hit_q) begin
				free_hit_q <= 1'b1;
				free_idx_q <= ridx_s1;
			end
			if ((op_q == OP_TOUCH || op_q == OP_INSERT) && hit) begin
				res_found_q <= 1'b1;
			end else if (op_q == OP_INSERT && last) begin
				res_found_q <= free_avail;
				res_full_q  <= !free_avail;
			end
			if (evict_now && res_count_q != COUNT_MAX) begin
				res_count_q <= res_count_q + 7'd1;
			end
		end
		if (load_out) begin
			out_found_q <= res_found_q;
			out_full_q  <= res_full_q;
			out_count_q <= res_count_q;
			out_frame_q <= frame_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.found         = out_found_q;
	assign rsp.table_full    = out_full_q;
	assign rsp.evicted_count = out_count_q;
	assign rsp.current_frame = out_frame_q;

endmodule

// ===== rtl/frame_idle_cache_evictor.sv =====
// top level of the frame idle cache evictor
//
// Asset cache table with frame-based idle eviction. Request beats carry an opcode (begin
// frame, touch, evict idle, insert) and an asset id; every request yields exactly one
// response beat with found, table_full, evicted_count and the frame counter after the
// operation. A two-deep request queue lets new beats in while the table engine is busy,
// and a response register holds a finished beat while the next one is being worked on.
// The table sits in two single-write, single-read rams and is walked one entry per cycle
// through their read port. A begin frame only steps the counter, and when the counter
// wraps every stamp is rewritten to 1; a touch or insert that hits entry k stops the walk
// there; a touch miss, an insert of a new id and an evict walk the whole table.
// After reset the engine clears every entry of the tag ram before it takes its
// first request; the queue fills meanwhile and the idle limit register (apb offset
// 0, reset 60) can be written at any time the engine is idle.
module frame_idle_cache_evictor import fice_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	fice_req_if.sink           req,
	fice_rsp_if.source         rsp
);

	logic [FRAME_W-1:0] max_idle_q;
	logic               q_valid;
	logic               q_pop;
	item_t              q_item;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == REG_MAX_IDLE_ADDR) ? max_idle_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_idle_q <= MAX_IDLE_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_MAX_IDLE_ADDR) begin
			max_idle_q <= pwdata;
		end
	end

	fice_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	fice_back #(.ENTRIES(ENTRIES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.max_idle (max_idle_q),
		.rsp      (rsp)
	);

	// back end only drains the queue when something is there
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// the engine never starts two operations back to back
	a_pop_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop)
		else $error("two operations started back to back");

	// found and table_full never come together
	a_found_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.found && rsp.table_full))
		else $error("response flags both found and full");

	// only an evict reports a count, and it never sets the lookup flags
	a_count_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.found || rsp.table_full)) |-> (rsp.evicted_count == '0))
		else $error("eviction count on a lookup response");

endmodule
